[design/rpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types and constants of the rolling Pearson correlation unit.
// ----------------------------------------------------------------------------
package rpc_pkg;

	localparam int SampleBits = 16;
	localparam int WindowMax  = 256;
	localparam int SlotBits   = 8;
	localparam int LenBits    = 9;
	localparam int SumBits    = 24;
	localparam int SqBits     = 40;
	localparam int CorrBits   = 16;
	localparam int LenReset   = 20;
	localparam int QueueDepth = 2;

	typedef struct packed {
		logic [LenBits-1:0]       n;
		logic signed [SumBits-1:0] sx;
		logic signed [SumBits-1:0] sy;
		logic signed [SqBits-1:0]  sxx;
		logic signed [SqBits-1:0]  syy;
		logic signed [SqBits-1:0]  sxy;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_READ,
		F_UPDATE
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_PROD,
		B_SPREAD,
		B_MUL,
		B_DIV,
		B_SQRT,
		B_DONE
	} back_state_t;

endpackage

[design/rpc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_front
// Takes sample pairs, keeps the window ring and running sums, and issues one
// job per full window to the queue.
// ----------------------------------------------------------------------------
module rpc_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [31:0]                      s_tdata,
	input  logic                             s_tuser,
	input  logic                             cfg_valid,
	input  logic [rpc_pkg::LenBits-1:0]      cfg_data,
	input  rpc_pkg::queue_status_t           q_status,
	output logic                             push,
	output rpc_pkg::job_t                    push_job
);
	import rpc_pkg::*;

	front_state_t state_q, state_d;

	logic signed [SampleBits-1:0] x_q, y_q;
	logic                         start_q;
	logic [SlotBits-1:0]          slot_q;
	logic [LenBits-1:0]           fill_q;
	logic [LenBits-1:0]           len_q;
	logic signed [SumBits-1:0]    sx_q, sy_q;
	logic signed [SqBits-1:0]     sxx_q, syy_q, sxy_q;
	logic [2*SampleBits-1:0]      ring_mem [WindowMax];
	logic [2*SampleBits-1:0]      rd_data_q;

	logic [LenBits-1:0]           n_eff;
	logic [SlotBits-1:0]          slot_eff, rd_addr;
	logic [LenBits-1:0]           fill_eff, fill_new;
	logic                         full_eff;
	logic signed [SampleBits-1:0] ox, oy;
	logic signed [SumBits-1:0]    sx_new, sy_new;
	logic signed [SqBits-1:0]     sxx_new, syy_new, sxy_new;
	logic signed [SqBits-1:0]     oxx, oyy, oxy, nxx, nyy, nxy;

	always_comb begin
		if (len_q < LenBits'(2)) begin
			n_eff = LenBits'(2);
		end else if (len_q > LenBits'(WindowMax)) begin
			n_eff = LenBits'(WindowMax);
		end else begin
			n_eff = len_q;
		end
	end

	assign slot_eff = start_q ? '0 : slot_q;
	assign rd_addr  = slot_eff - n_eff[SlotBits-1:0];
	assign fill_eff = start_q ? '0 : fill_q;
	assign full_eff = (fill_eff >= n_eff);
	assign fill_new = full_eff ? n_eff : fill_eff + LenBits'(1);

	assign ox = rd_data_q[SampleBits-1:0];
	assign oy = rd_data_q[2*SampleBits-1:SampleBits];
	assign oxx = SqBits'(ox * ox);
	assign oyy = SqBits'(oy * oy);
	assign oxy = SqBits'(ox * oy);
	assign nxx = SqBits'(x_q * x_q);
	assign nyy = SqBits'(y_q * y_q);
	assign nxy = SqBits'(x_q * y_q);

	always_comb begin
		sx_new  = start_q ? '0 : sx_q;
		sy_new  = start_q ? '0 : sy_q;
		sxx_new = start_q ? '0 : sxx_q;
		syy_new = start_q ? '0 : syy_q;
		sxy_new = start_q ? '0 : sxy_q;
		if (full_eff) begin
			sx_new  = sx_new - SumBits'(ox);
			sy_new  = sy_new - SumBits'(oy);
			sxx_new = sxx_new - oxx;
			syy_new = syy_new - oyy;
			sxy_new = sxy_new - oxy;
		end
		sx_new  = sx_new + SumBits'(x_q);
		sy_new  = sy_new + SumBits'(y_q);
		sxx_new = sxx_new + nxx;
		syy_new = syy_new + nyy;
		sxy_new = sxy_new + nxy;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (s_tvalid && s_tready) state_d = F_READ;
			end
			F_READ:   state_d = F_UPDATE;
			F_UPDATE: state_d = F_IDLE;
			default:  state_d = F_IDLE;
		endcase
	end

	// a free queue slot at accept time stays free until this item's push
	always_comb begin
		s_tready = 1'b0;
		push     = 1'b0;
		case (state_q)
			F_IDLE:   s_tready = !q_status.full;
			F_UPDATE: push = (fill_new >= n_eff);
			default: begin
				s_tready = 1'b0;
				push     = 1'b0;
			end
		endcase
	end

	assign push_job.n   = n_eff;
	assign push_job.sx  = sx_new;
	assign push_job.sy  = sy_new;
	assign push_job.sxx = sxx_new;
	assign push_job.syy = syy_new;
	assign push_job.sxy = sxy_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			len_q   <= LenBits'(LenReset);
			slot_q  <= '0;
			fill_q  <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			sxx_q   <= '0;
			syy_q   <= '0;
			sxy_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				len_q  <= cfg_data;
				slot_q <= '0;
				fill_q <= '0;
				sx_q   <= '0;
				sy_q   <= '0;
				sxx_q  <= '0;
				syy_q  <= '0;
				sxy_q  <= '0;
			end else if (state_q == F_UPDATE) begin
				slot_q <= slot_eff + SlotBits'(1);
				fill_q <= fill_new;
				sx_q   <= sx_new;
				sy_q   <= sy_new;
				sxx_q  <= sxx_new;
				syy_q  <= syy_new;
				sxy_q  <= sxy_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			x_q     <= s_tdata[SampleBits-1:0];
			y_q     <= s_tdata[2*SampleBits-1:SampleBits];
			start_q <= s_tuser;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_READ) rd_data_q <= ring_mem[rd_addr];
		if (state_q == F_UPDATE) ring_mem[slot_eff] <= {y_q, x_q};
	end

endmodule

[design/rpc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_queue
// Short job queue between the window front and the arithmetic back.
// ----------------------------------------------------------------------------
module rpc_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  rpc_pkg::job_t          push_job,
	input  logic                   pop,
	output rpc_pkg::job_t          pop_job,
	output rpc_pkg::queue_status_t status
);
	import rpc_pkg::*;

	localparam int PtrBits = $clog2(QueueDepth);

	job_t               entry_q [QueueDepth];
	logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
	logic [PtrBits:0]   count_q;

	assign status.full  = (count_q == (PtrBits+1)'(QueueDepth));
	assign status.empty = (count_q == '0);
	assign pop_job      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PtrBits'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PtrBits'(1);
			if (push && !pop) begin
				count_q <= count_q + (PtrBits+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PtrBits+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_job;
	end

endmodule

[design/rpc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_back
// Turns window sums into a rounded Q2.14 correlation: products, spreads,
// split wide products, a restoring divider and a bitwise square root.
// ----------------------------------------------------------------------------
module rpc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rpc_pkg::queue_status_t        q_status,
	input  rpc_pkg::job_t                 pop_job,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rpc_pkg::CorrBits-1:0]  m_tdata,
	output logic                          m_tuser
);
	import rpc_pkg::*;

	localparam int HalfBits = 24;
	localparam int VarBits  = 2 * HalfBits;
	localparam int ProdBits = 2 * VarBits;
	localparam int QBits    = 31;
	localparam int ShBits   = ProdBits + QBits - 1;
	localparam int RootBits = 16;

	back_state_t state_q, state_d;

	job_t                       job_q;
	logic [VarBits:0]           nsxx_q, nsyy_q;
	logic [VarBits-1:0]         sx2_q, sy2_q;
	logic signed [VarBits+1:0]  nsxy_q;
	logic signed [VarBits-1:0]  sxsy_q;
	logic [VarBits-1:0]         a_q, b_q, cmag_q;
	logic                       neg_q;
	logic [ProdBits-1:0]        c2_q, ab_q;
	logic [1:0]                 mcnt_q;
	logic [4:0]                 dcnt_q;
	logic [3:0]                 scnt_q;
	logic [ShBits:0]            rem_q;
	logic [ShBits-1:0]          dsh_q;
	logic [QBits-1:0]           quo_q;
	logic [RootBits-1:0]        root_q;
	logic                       out_valid_q;
	logic [CorrBits-1:0]        out_corr_q;
	logic                       out_flat_q;

	logic [HalfBits-1:0]        sx_mag, sy_mag;
	logic signed [VarBits+1:0]  c_full;
	logic [HalfBits-1:0]        c_part_i, c_part_j, a_part, b_part;
	logic [ProdBits-1:0]        c_pp, ab_pp;
	logic [ProdBits-1:0]        c_pp_sh, ab_pp_sh;
	logic                       div_take;
	logic [RootBits-1:0]        root_try;
	logic [2*RootBits-1:0]      root_sq;
	logic [RootBits-1:0]        q_mag;
	logic                       flat;
	logic                       load_out;

	assign sx_mag = job_q.sx[SumBits-1] ? HalfBits'(-job_q.sx) : HalfBits'(job_q.sx);
	assign sy_mag = job_q.sy[SumBits-1] ? HalfBits'(-job_q.sy) : HalfBits'(job_q.sy);
	assign c_full = nsxy_q - {{2{sxsy_q[VarBits-1]}}, sxsy_q};
	assign flat   = (a_q == '0) || (b_q == '0);

	// partial product index: mcnt_q[1] picks the first factor half
	assign c_part_i = mcnt_q[1] ? cmag_q[VarBits-1:HalfBits] : cmag_q[HalfBits-1:0];
	assign c_part_j = mcnt_q[0] ? cmag_q[VarBits-1:HalfBits] : cmag_q[HalfBits-1:0];
	assign a_part   = mcnt_q[1] ? a_q[VarBits-1:HalfBits] : a_q[HalfBits-1:0];
	assign b_part   = mcnt_q[0] ? b_q[VarBits-1:HalfBits] : b_q[HalfBits-1:0];
	assign c_pp     = ProdBits'(c_part_i * c_part_j);
	assign ab_pp    = ProdBits'(a_part * b_part);
	assign c_pp_sh  = c_pp << (HalfBits * (int'(mcnt_q[1]) + int'(mcnt_q[0])));
	assign ab_pp_sh = ab_pp << (HalfBits * (int'(mcnt_q[1]) + int'(mcnt_q[0])));

	assign div_take = ({1'b0, dsh_q} <= rem_q);
	assign root_try = root_q | (RootBits'(1) << scnt_q);
	assign root_sq  = (2*RootBits)'(root_try * root_try);
	assign q_mag    = RootBits'(({1'b0, root_q} + (RootBits+1)'(1)) >> 1);
	assign load_out = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_status.empty) state_d = B_PROD;
			end
			B_PROD:   state_d = B_SPREAD;
			B_SPREAD: state_d = B_MUL;
			B_MUL: begin
				if (flat) begin
					state_d = B_DONE;
				end else if (mcnt_q == 2'd3) begin
					state_d = B_DIV;
				end
			end
			B_DIV: begin
				if (dcnt_q == '0) state_d = B_SQRT;
			end
			B_SQRT: begin
				if (scnt_q == '0) state_d = B_DONE;
			end
			B_DONE: begin
				if (load_out) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		case (state_q)
			B_IDLE:  pop = !q_status.empty;
			default: pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_DONE && load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				job_q <= pop_job;
			end
			B_PROD: begin
				nsxx_q <= job_q.n * (VarBits+1)'(job_q.sxx);
				nsyy_q <= job_q.n * (VarBits+1)'(job_q.syy);
				sx2_q  <= VarBits'(sx_mag * sx_mag);
				sy2_q  <= VarBits'(sy_mag * sy_mag);
				nsxy_q <= (VarBits+2)'($signed({1'b0, job_q.n}) * job_q.sxy);
				sxsy_q <= VarBits'(job_q.sx * job_q.sy);
			end
			B_SPREAD: begin
				a_q    <= VarBits'(nsxx_q - (VarBits+1)'(sx2_q));
				b_q    <= VarBits'(nsyy_q - (VarBits+1)'(sy2_q));
				neg_q  <= c_full[VarBits+1];
				cmag_q <= c_full[VarBits+1] ? VarBits'(-c_full) : VarBits'(c_full);
				c2_q   <= '0;
				ab_q   <= '0;
				mcnt_q <= '0;
			end
			B_MUL: begin
				mcnt_q <= mcnt_q + 2'd1;
				if (mcnt_q == 2'd3) begin
					rem_q  <= {1'b0, (c2_q + c_pp_sh), (QBits-1)'(0)};
					dsh_q  <= {(ab_q + ab_pp_sh), (QBits-1)'(0)};
					quo_q  <= '0;
					dcnt_q <= 5'(QBits - 1);
				end else begin
					c2_q <= c2_q + c_pp_sh;
					ab_q <= ab_q + ab_pp_sh;
				end
			end
			B_DIV: begin
				if (div_take) rem_q <= rem_q - {1'b0, dsh_q};
				quo_q  <= {quo_q[QBits-2:0], div_take};
				dsh_q  <= dsh_q >> 1;
				dcnt_q <= dcnt_q - 5'd1;
				root_q <= '0;
				scnt_q <= 4'(RootBits - 1);
			end
			B_SQRT: begin
				if (root_sq <= (2*RootBits)'(quo_q)) root_q <= root_try;
				scnt_q <= scnt_q - 4'd1;
			end
			B_DONE: begin
				if (load_out) begin
					out_flat_q <= flat;
					if (flat) begin
						out_corr_q <= '0;
					end else begin
						out_corr_q <= neg_q ? CorrBits'(-q_mag) : CorrBits'(q_mag);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_corr_q;
	assign m_tuser  = out_flat_q;

endmodule

[design/rolling_pearson_correlation_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_pearson_correlation_unit
// Sliding-window Pearson correlation of two signed sample series, Q2.14 out.
// ----------------------------------------------------------------------------
// front takes a new item only after the ring read and sum update of the last one
// back works one window at a time through products, spreads, the split multiply, the
// 31-step divider and the 16-step square root, skipping the last two when a series is flat;
// a two-entry job queue sits between; async reset clears sums, fill count, slot and queue;
// window length resets to 20; ring contents are not reset, and a ring read is used only once written
module rolling_pearson_correlation_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // x_sample, y_sample
	input  logic        s_tuser,   // series_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // correlation
	output logic        m_tuser,   // zero_variance
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data   // window_length
);
	import rpc_pkg::*;

	queue_status_t q_status;
	job_t          push_job, pop_job;
	logic          push, pop;

	assign cfg_ready = 1'b1;

	rpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.q_status (q_status),
		.push     (push),
		.push_job (push_job)
	);

	rpc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.pop_job (pop_job),
		.status  (q_status)
	);

	rpc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_status(q_status),
		.pop_job (pop_job),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule
